### sv/anemometer_pulse_wind_speed_unit_defines.svh
// Assertion helpers shared by the wind speed unit.
`ifndef ANEMOMETER_PULSE_WIND_SPEED_UNIT_DEFINES_SVH
`define ANEMOMETER_PULSE_WIND_SPEED_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define APWS_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define APWS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

### sv/apws_pkg.sv
package apws_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SQUARE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LINEAR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_MPS  = 3'd4;

    localparam logic [15:0] RST_WINDOW_MS   = 16'd10000;
    localparam logic [15:0] RST_COEF_SQUARE = 16'hFFB6;   // -74
    localparam logic [15:0] RST_COEF_LINEAR = 16'd5677;
    localparam logic [15:0] RST_COEF_OFFSET = 16'd5757;
    localparam logic [15:0] RST_CUTOFF_MPS  = 16'd384;

    localparam int RPS_W      = 24;                        // rotations/s, Q.8, capped
    localparam int RSQ_SHIFT  = 8;
    localparam int COEF_W     = 16;
    localparam int MCAND_W    = 2 * RPS_W - RSQ_SHIFT;     // rps^2 >> 8
    localparam int ACC_W      = MCAND_W + COEF_W + 1;      // Q.20 polynomial sum
    localparam int FRAC_SHIFT = 12;
    localparam int MPS_W      = 16;
    localparam int KMH_W      = 18;

    localparam logic [15:0] KMH_DIVISOR = 16'd5;           // x18 / 5 = x3.6
    localparam logic [MCAND_W-1:0] OFS_SCALE = MCAND_W'(256);

    typedef struct packed {
        logic pulse_edge;
        logic ms_tick;
    } in_word_t;

    typedef struct packed {
        logic [MPS_W-1:0] speed_mps;
        logic [KMH_W-1:0] speed_kmph;
        logic [15:0]      window_pulses;
        logic             pulses_overflowed;
    } out_word_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic is_signed;
    } mac_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef struct packed {
        logic fire;
        logic ovf;
    } cnt_stat_t;

endpackage

### sv/apws_count.sv
module apws_count #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  apws_pkg::in_word_t   in_word,
    input  logic [15:0]          win_eff,
    output logic [COUNT_WIDTH-1:0] count,
    output apws_pkg::cnt_stat_t  stat
);
    import apws_pkg::*;

    logic [COUNT_WIDTH-1:0] pulse_reg, pulse_next;
    logic [15:0]            elapsed_reg, elapsed_next;
    logic                   ovf_reg, ovf_next;

    always_comb begin
        pulse_next   = pulse_reg;
        ovf_next     = ovf_reg;
        elapsed_next = elapsed_reg;
        if (in_word.pulse_edge) begin
            if (&pulse_reg) begin
                ovf_next = 1'b1;
            end else begin
                pulse_next = pulse_reg + COUNT_WIDTH'(1);
            end
        end
        if (in_word.ms_tick && !(&elapsed_reg)) begin
            elapsed_next = elapsed_reg + 16'd1;
        end
    end

    // count/ovf are the post-update values, taken by the sequencer on fire
    assign count     = pulse_next;
    assign stat.ovf  = ovf_next;
    assign stat.fire = accept && (elapsed_next >= win_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_reg   <= '0;
            elapsed_reg <= '0;
            ovf_reg     <= 1'b0;
        end else if (accept) begin
            if (stat.fire) begin
                pulse_reg   <= '0;
                elapsed_reg <= '0;
                ovf_reg     <= 1'b0;
            end else begin
                pulse_reg   <= pulse_next;
                elapsed_reg <= elapsed_next;
                ovf_reg     <= ovf_next;
            end
        end
    end

endmodule

### sv/apws_div.sv
module apws_div #(
    parameter int NUM_W = 34
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [NUM_W-1:0]           numer,
    input  logic [15:0]                denom,
    output logic [apws_pkg::RPS_W-1:0] quot,
    output apws_pkg::unit_stat_t       stat
);
    import apws_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] num_reg;
    logic [15:0]      den_reg;
    logic [15:0]      rem_reg;
    logic [RPS_W-1:0] quo_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [16:0] trial;
    logic [16:0] diff;
    logic        fits;
    logic        last;

    // restoring division, one numerator bit per cycle, MSB first
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};
    assign last  = cnt_reg == CNT_W'(NUM_W - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (last) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= fits ? diff[15:0] : trial[15:0];
            quo_reg <= {quo_reg[RPS_W-2:0], fits};
            ovf_reg <= ovf_reg | quo_reg[RPS_W-1];   // sticky: quotient went past the cap
        end
    end

    assign quot      = ovf_reg ? '1 : quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && last;

endmodule

### sv/apws_mac.sv
module apws_mac (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  apws_pkg::mac_cmd_t           cmd,
    input  logic [apws_pkg::MCAND_W-1:0] mcand,
    input  logic [apws_pkg::RPS_W-1:0]   mplier,
    output logic [apws_pkg::ACC_W-1:0]   acc,
    output apws_pkg::unit_stat_t         stat
);
    import apws_pkg::*;

    localparam int STEP_W = $clog2(RPS_W);

    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  mc_reg;
    logic [RPS_W-1:0]  mp_reg;
    logic              sgn_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;

    logic              last;
    logic [ACC_W-1:0]  addend;
    logic [ACC_W-1:0]  acc_next;

    // shift-add, one multiplier bit per cycle, LSB first; a signed
    // multiplier's top bit carries negative weight
    assign last     = sgn_reg ? (cnt_reg == STEP_W'(COEF_W - 1))
                              : (cnt_reg == STEP_W'(RPS_W - 1));
    assign addend   = mp_reg[0] ? mc_reg : '0;
    assign acc_next = (last && sgn_reg) ? acc_reg - addend : acc_reg + addend;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (cmd.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + STEP_W'(1);
            if (last) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            if (cmd.clear) begin
                acc_reg <= '0;
            end
            mc_reg  <= ACC_W'(mcand);
            mp_reg  <= mplier;
            sgn_reg <= cmd.is_signed;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            mc_reg  <= {mc_reg[ACC_W-2:0], 1'b0};
            mp_reg  <= {1'b0, mp_reg[RPS_W-1:1]};
        end
    end

    assign acc       = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && last;

endmodule

### sv/anemometer_pulse_wind_speed_unit.sv
// Cup anemometer wind speed unit.
// Input channel (s_valid/s_ready/s_word): one word per sample, carrying a
// pulse edge flag and a millisecond tick flag. Words that do not close the
// measurement window are taken one per cycle while the block is idle.
// When the tick count reaches window_ms (0 treated as 1), the word that closes
// the window starts the calibration: rps = count*256000/window through a
// bit-serial divider, then rps^2 and the Q4.12 quadratic through a shift-add
// MAC, then km/h = m/s*18/5 through the same divider.
// The calculation runs the two COUNT_WIDTH+18 bit divider passes and the MAC
// passes in turn; s_ready is low from the closing word until the result
// is loaded into the output register.
// Result channel (m_valid/m_ready/m_word): one word per window, held in an
// output register. Non-closing words are still taken while a result waits;
// a closing word whose result is finished while the previous one is still
// stalled holds the block (s_ready low) until m_ready frees the register.
// Configuration: cfg_we/cfg_index/cfg_wdata, single-cycle writes, indexes
// beyond the register list are dropped. Write only while the block is idle.
// Reset (aresetn low, synchronous) clears the counters, drops any pending
// result and loads the default window and calibration.
`include "anemometer_pulse_wind_speed_unit_defines.svh"

module anemometer_pulse_wind_speed_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  apws_pkg::in_word_t              s_word,
    output logic                            m_valid,
    input  logic                            m_ready,
    output apws_pkg::out_word_t             m_word,
    input  logic                            cfg_we,
    input  logic [apws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [apws_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import apws_pkg::*;

    localparam int NUM_W  = COUNT_WIDTH + 18;   // count*125 with 11 zero bits below
    localparam int C125_W = COUNT_WIDTH + 7;
    localparam int KNUM_W = MPS_W + 5;          // mps*18

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_RPS   = 9'b000000010,   // divider: count*256000 / window
        ST_SQR   = 9'b000000100,   // MAC: rps * rps
        ST_TSQ   = 9'b000001000,   // MAC: coef_square * rsq
        ST_TLIN  = 9'b000010000,   // MAC: + coef_linear * rps
        ST_TOFS  = 9'b000100000,   // MAC: + coef_offset * 256
        ST_SCALE = 9'b001000000,   // clamp, saturate, cutoff
        ST_KMH   = 9'b010000000,   // divider: mps*18 / 5
        ST_OUT   = 9'b100000000    // wait for output register
    } state_t;

    state_t state_reg, state_next;
    logic   kick_reg, kick_next;   // first cycle of a unit state: issue start

    // configuration
    logic [15:0] window_ms_reg;
    logic [15:0] coef_square_reg;
    logic [15:0] coef_linear_reg;
    logic [15:0] coef_offset_reg;
    logic [15:0] cutoff_reg;
    logic [15:0] win_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_ms_reg   <= RST_WINDOW_MS;
            coef_square_reg <= RST_COEF_SQUARE;
            coef_linear_reg <= RST_COEF_LINEAR;
            coef_offset_reg <= RST_COEF_OFFSET;
            cutoff_reg      <= RST_CUTOFF_MPS;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_WINDOW_MS:   window_ms_reg   <= cfg_wdata;
                REG_COEF_SQUARE: coef_square_reg <= cfg_wdata;
                REG_COEF_LINEAR: coef_linear_reg <= cfg_wdata;
                REG_COEF_OFFSET: coef_offset_reg <= cfg_wdata;
                REG_CUTOFF_MPS:  cutoff_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign win_eff = (window_ms_reg == 16'd0) ? 16'd1 : window_ms_reg;

    // input side
    logic                   accept;
    logic [COUNT_WIDTH-1:0] cnt_count;
    cnt_stat_t              cnt_stat;

    assign s_ready = state_reg == ST_IDLE;
    assign accept  = s_valid && s_ready;

    apws_count #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_count (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_word (s_word),
        .win_eff (win_eff),
        .count   (cnt_count),
        .stat    (cnt_stat)
    );

    // window snapshot, taken on the closing word
    logic [COUNT_WIDTH-1:0] snap_count_reg;
    logic                   snap_ovf_reg;
    logic [15:0]            pulses16;

    always_ff @(posedge aclk) begin
        if (cnt_stat.fire) begin
            snap_count_reg <= cnt_count;
            snap_ovf_reg   <= cnt_stat.ovf;
        end
    end

    generate
        if (COUNT_WIDTH > 16) begin : g_pulse_sat
            assign pulses16 = (|snap_count_reg[COUNT_WIDTH-1:16]) ? 16'hFFFF
                                                                   : snap_count_reg[15:0];
        end else begin : g_pulse_ext
            assign pulses16 = 16'(snap_count_reg);
        end
    endgenerate

    // divider operands
    logic [C125_W-1:0] count125;
    logic [KNUM_W-1:0] mps18;
    logic [NUM_W-1:0]  div_numer;
    logic [15:0]       div_denom;
    logic              div_start;
    logic [RPS_W-1:0]  div_q;
    unit_stat_t        div_stat;

    // count*125 = count*128 - count*4 + count
    assign count125 = {snap_count_reg, 7'b0} - {5'b0, snap_count_reg, 2'b0}
                    + {7'b0, snap_count_reg};

    logic [15:0] mps_reg;
    assign mps18 = {1'b0, mps_reg, 4'b0} + {4'b0, mps_reg, 1'b0};

    assign div_start = kick_reg && (state_reg == ST_RPS || state_reg == ST_KMH);
    assign div_numer = (state_reg == ST_KMH) ? NUM_W'(mps18) : {count125, 11'b0};
    assign div_denom = (state_reg == ST_KMH) ? KMH_DIVISOR : win_eff;

    apws_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .denom   (div_denom),
        .quot    (div_q),
        .stat    (div_stat)
    );

    // MAC operands
    mac_cmd_t           mac_cmd;
    logic [MCAND_W-1:0] mac_mcand;
    logic [RPS_W-1:0]   mac_mplier;
    logic [ACC_W-1:0]   mac_acc;
    unit_stat_t         mac_stat;
    logic [RPS_W-1:0]   rps_reg;

    always_comb begin
        mac_cmd.start     = 1'b0;
        mac_cmd.clear     = 1'b0;
        mac_cmd.is_signed = 1'b1;
        mac_mcand         = '0;
        mac_mplier        = '0;
        case (state_reg)
            ST_SQR: begin
                mac_cmd.start     = kick_reg;
                mac_cmd.clear     = 1'b1;
                mac_cmd.is_signed = 1'b0;
                mac_mcand         = MCAND_W'(div_q);
                mac_mplier        = div_q;
            end
            ST_TSQ: begin
                mac_cmd.start = kick_reg;
                mac_cmd.clear = 1'b1;
                mac_mcand     = mac_acc[2*RPS_W-1:RSQ_SHIFT];   // floor(rps^2 / 256)
                mac_mplier    = RPS_W'(coef_square_reg);
            end
            ST_TLIN: begin
                mac_cmd.start = kick_reg;
                mac_mcand     = MCAND_W'(rps_reg);
                mac_mplier    = RPS_W'(coef_linear_reg);
            end
            ST_TOFS: begin
                mac_cmd.start = kick_reg;
                mac_mcand     = OFS_SCALE;
                mac_mplier    = RPS_W'(coef_offset_reg);
            end
            default: ;
        endcase
    end

    apws_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mac_cmd),
        .mcand   (mac_mcand),
        .mplier  (mac_mplier),
        .acc     (mac_acc),
        .stat    (mac_stat)
    );

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SQR && kick_reg) begin
            rps_reg <= div_q;
        end
    end

    // Q.20 sum -> Q8.8 m/s: negative or zero gives 0, saturate, then cutoff
    logic        acc_pos;
    logic [15:0] mps_sat;
    logic [15:0] mps_val;

    assign acc_pos = !mac_acc[ACC_W-1] && (|mac_acc);
    assign mps_sat = (|mac_acc[ACC_W-2:FRAC_SHIFT+MPS_W]) ? 16'hFFFF
                                                          : mac_acc[FRAC_SHIFT+MPS_W-1:FRAC_SHIFT];
    assign mps_val = (!acc_pos || mps_sat <= cutoff_reg) ? 16'd0 : mps_sat;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCALE) begin
            mps_reg <= mps_val;
        end
    end

    // sequencer
    logic out_load;
    logic m_valid_reg, m_valid_next;
    out_word_t m_word_reg;

    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        kick_next  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (cnt_stat.fire) begin
                    state_next = ST_RPS;
                    kick_next  = 1'b1;
                end
            end
            ST_RPS: begin
                if (div_stat.done) begin
                    state_next = ST_SQR;
                    kick_next  = 1'b1;
                end
            end
            ST_SQR: begin
                if (mac_stat.done) begin
                    state_next = ST_TSQ;
                    kick_next  = 1'b1;
                end
            end
            ST_TSQ: begin
                if (mac_stat.done) begin
                    state_next = ST_TLIN;
                    kick_next  = 1'b1;
                end
            end
            ST_TLIN: begin
                if (mac_stat.done) begin
                    state_next = ST_TOFS;
                    kick_next  = 1'b1;
                end
            end
            ST_TOFS: begin
                if (mac_stat.done) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                state_next = ST_KMH;
                kick_next  = 1'b1;
            end
            ST_KMH: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kick_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            kick_reg  <= kick_next;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_word_reg.speed_mps         <= mps_reg;
            m_word_reg.speed_kmph        <= div_q[KMH_W-1:0];
            m_word_reg.window_pulses     <= pulses16;
            m_word_reg.pulses_overflowed <= snap_ovf_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    // checks
    `APWS_ASSERT_IMPL(a_units_exclusive, aclk, aresetn, div_stat.busy, !mac_stat.busy)
    `APWS_ASSERT_IMPL(a_idle_units_quiet, aclk, aresetn, state_reg == ST_IDLE, !div_stat.busy && !mac_stat.busy)
    `APWS_ASSERT_NEXT(a_load_shows_word, aclk, aresetn, out_load, m_valid && state_reg == ST_IDLE)
    `APWS_ASSERT_IMPL(a_kmh_tracks_mps, aclk, aresetn, m_valid, (m_word.speed_mps == 16'd0) == (m_word.speed_kmph == 18'd0))

endmodule

### tb/tb_anemometer_pulse_wind_speed_unit.sv
`timescale 1ns / 1ps

module tb_anemometer_pulse_wind_speed_unit;
    import apws_pkg::*;

    // Calculation span from the closing word to m_valid, at COUNT_WIDTH = 16.
    localparam int CALC_CYCLES    = 2 * 16 + 116;
    localparam int DRAIN_PAUSE    = CALC_CYCLES + 20;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RAND_WORDS     = 1800;
    localparam int RAND_REPORTS   = 40;

    typedef enum logic {ROW_REG, ROW_WORD} row_kind_t;

    // One line of the directed script: a register write or a sample word.
    // Words with a typed-in report use it; the rest use the local wind model.
    typedef struct {
        row_kind_t           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]          data;
        in_word_t             word;
        bit                   known;
        out_word_t            report;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_word_t s_word = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_word_t m_word;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Local copy of the calibration registers, mirrored on every write.
    logic [15:0] reg_window = RST_WINDOW_MS;
    logic [15:0] reg_square = RST_COEF_SQUARE;
    logic [15:0] reg_linear = RST_COEF_LINEAR;
    logic [15:0] reg_offset = RST_COEF_OFFSET;
    logic [15:0] reg_cutoff = RST_CUTOFF_MPS;

    // Local copy of the window state.
    logic [15:0] pulse_cnt = '0;
    logic [15:0] ms_elapsed = '0;
    logic        ovf_seen = 1'b0;

    out_word_t reports_due[$];
    row_t      script[$];
    int        reports_predicted = 0;
    int        err_count = 0;
    int        stalled = 0;
    int        rx_hold = 0;
    bit        tx_idle = 1'b1;
    bit        rx_eager = 1'b0;
    bit        unsettled = 1'b0;

    anemometer_pulse_wind_speed_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Wind model: advances the window by one sample word and, if the window
    // closes, returns 1 with the report that the block must produce.
    function automatic bit advance_meter(input in_word_t w, output out_word_t rep);
        longint unsigned win;
        longint unsigned rps;
        longint unsigned rsq;
        longint          poly;
        longint          mps;
        rep = '0;
        // edge first (saturating, marks overflow), then the tick
        if (w.pulse_edge) begin
            if (pulse_cnt == 16'hFFFF)
                ovf_seen = 1'b1;
            else
                pulse_cnt = pulse_cnt + 16'd1;
        end
        if (w.ms_tick && ms_elapsed != 16'hFFFF)
            ms_elapsed = ms_elapsed + 16'd1;
        // zero window behaves as one tick
        win = (reg_window == 16'd0) ? 64'd1 : 64'(reg_window);
        if (64'(ms_elapsed) < win)
            return 1'b0;
        // rotations/s in Q.8, capped to 24 bits before the polynomial
        rps = (64'(pulse_cnt) * 64'd256000) / win;
        if (rps > 64'hFF_FFFF)
            rps = 64'hFF_FFFF;
        rsq = (rps * rps) >> 8;
        // Q.20 sum of the Q4.12 quadratic
        poly = longint'($signed(reg_square)) * longint'(rsq)
             + longint'($signed(reg_linear)) * longint'(rps)
             + longint'($signed(reg_offset)) * 256;
        if (poly <= 0) begin
            mps = 0;
        end else begin
            mps = poly >>> 12;
            if (mps > 65535)
                mps = 65535;
            if (mps <= longint'(reg_cutoff))
                mps = 0;
        end
        rep.speed_mps         = mps[15:0];
        rep.speed_kmph        = 18'((mps * 36) / 10);
        rep.window_pulses     = pulse_cnt;
        rep.pulses_overflowed = ovf_seen;
        pulse_cnt  = '0;
        ms_elapsed = '0;
        ovf_seen   = 1'b0;
        return 1'b1;
    endfunction

    function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        row_t r;
        r = '{ROW_REG, idx, data, '0, 1'b0, '0};
        return r;
    endfunction

    function automatic row_t word_row(input logic pulse, input logic tick);
        row_t r;
        r = '{ROW_WORD, '0, '0, {pulse, tick}, 1'b0, '0};
        return r;
    endfunction

    function automatic row_t known_row(input logic pulse, input logic tick,
                                       input logic [15:0] mps, input logic [17:0] kmph,
                                       input logic [15:0] pulses, input logic ovf);
        row_t r;
        r = '{ROW_WORD, '0, '0, {pulse, tick}, 1'b1, {mps, kmph, pulses, ovf}};
        return r;
    endfunction

    // Random coefficient: nominal, full range, an extreme, or a modest value.
    function automatic logic [15:0] pick_coef(input logic [15:0] nominal);
        case ($urandom_range(3, 0))
            0: return nominal;
            1: return 16'($urandom);
            2: begin
                case ($urandom_range(3, 0))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default: return 16'($urandom_range(4095, 0)) ^ ($urandom_range(1, 0) ? 16'hFFFF : 16'h0000);
        endcase
    endfunction

    // Drop valid, let every due report come out, then give the block its
    // full calculation time in case a closing word is still being worked on.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (reports_due.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_PAUSE) @(negedge aclk);
        unsettled = 1'b0;
    endtask

    // Register write; cfg_we is dropped by the next sample word.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        if (unsettled)
            settle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_WINDOW_MS:   reg_window = data;
            REG_COEF_SQUARE: reg_square = data;
            REG_COEF_LINEAR: reg_linear = data;
            REG_COEF_OFFSET: reg_offset = data;
            REG_CUTOFF_MPS:  reg_cutoff = data;
            default: ;  // unmapped index, dropped
        endcase
    endtask

    // Offer one sample word and hold it until taken.
    task automatic push_word(input logic pulse, input logic tick,
                             input bit has_known, input out_word_t known);
        int        gap;
        in_word_t  w;
        out_word_t rep;
        gap = tx_idle ? $urandom_range(10, 0) : 0;
        w.pulse_edge = pulse;
        w.ms_tick    = tick;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        if (advance_meter(w, rep)) begin
            reports_due.push_back(has_known ? known : rep);
            reports_predicted++;
        end
        unsettled = 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // New calibration for a random phase. Windows are kept short most of
    // the time so that reports are frequent.
    task automatic randomize_setup();
        logic [15:0] win;
        logic [15:0] cut;
        case ($urandom_range(9, 0))
            0: win = 16'd0;
            1: win = 16'd1;
            8: win = 16'($urandom_range(200, 25));
            9: win = 16'($urandom);
            default: win = 16'($urandom_range(24, 2));
        endcase
        case ($urandom_range(3, 0))
            0: cut = 16'($urandom_range(1023, 0));
            1: cut = 16'($urandom);
            2: cut = 16'h0000;
            default: cut = 16'hFFFF;
        endcase
        write_reg(REG_WINDOW_MS, win);
        write_reg(REG_COEF_SQUARE, pick_coef(RST_COEF_SQUARE));
        write_reg(REG_COEF_LINEAR, pick_coef(RST_COEF_LINEAR));
        write_reg(REG_COEF_OFFSET, pick_coef(RST_COEF_OFFSET));
        write_reg(REG_CUTOFF_MPS, cut);
        if ($urandom_range(3, 0) == 0)
            write_reg(CFG_IDX_W'($urandom_range(7, 5)), 16'($urandom));
    endtask

    // Result side: hold m_ready low for a drawn number of cycles once a
    // report is offered, then keep it high until the report is taken.
    always @(negedge aclk) begin
        if (m_valid && rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Report checker and watchdog.
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
                stalled = 0;
            else
                stalled++;
            if (m_valid && m_ready) begin
                rx_hold = rx_eager ? 0 : $urandom_range(10, 0);
                if (reports_due.size() == 0) begin
                    err_count++;
                    $display("%0t: report with none due: mps %0d kmph %0d pulses %0d ovf %0b",
                             $time, m_word.speed_mps, m_word.speed_kmph,
                             m_word.window_pulses, m_word.pulses_overflowed);
                end else begin
                    want = reports_due.pop_front();
                    if (m_word.speed_mps !== want.speed_mps) begin
                        err_count++;
                        $display("%0t: speed_mps expected %0d, got %0d",
                                 $time, want.speed_mps, m_word.speed_mps);
                    end
                    if (m_word.speed_kmph !== want.speed_kmph) begin
                        err_count++;
                        $display("%0t: speed_kmph expected %0d, got %0d",
                                 $time, want.speed_kmph, m_word.speed_kmph);
                    end
                    if (m_word.window_pulses !== want.window_pulses) begin
                        err_count++;
                        $display("%0t: window_pulses expected %0d, got %0d",
                                 $time, want.window_pulses, m_word.window_pulses);
                    end
                    if (m_word.pulses_overflowed !== want.pulses_overflowed) begin
                        err_count++;
                        $display("%0t: pulses_overflowed expected %0b, got %0b",
                                 $time, want.pulses_overflowed, m_word.pulses_overflowed);
                    end
                end
            end
            if (stalled >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d reports due",
                         $time, stalled, reports_due.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int pulse_pct;
        int tick_pct;
        int span;
        int rand_words;
        int report_goal;

        // Directed script. Window 0 acts as a single tick so that every
        // tick closes a window.
        script = '{
            reg_row(REG_WINDOW_MS, 16'd0),
            word_row(1'b0, 1'b0),
            // empty window: offset alone stays under the default cutoff
            known_row(1'b0, 1'b1, 16'd0, 18'd0, 16'd0, 1'b0),
            word_row(1'b1, 1'b0),
            // two pulses in one tick: quadratic term drives the sum negative
            known_row(1'b1, 1'b1, 16'd0, 18'd0, 16'd2, 1'b0),
            reg_row(REG_COEF_SQUARE, 16'h0000),
            reg_row(REG_COEF_LINEAR, 16'h7FFF),
            reg_row(REG_COEF_OFFSET, 16'h7FFF),
            reg_row(REG_CUTOFF_MPS, 16'h0000),
            // m/s saturates, km/h follows at its top value
            known_row(1'b1, 1'b1, 16'd65535, 18'd235926, 16'd1, 1'b0),
            reg_row(REG_COEF_SQUARE, 16'h8000),
            reg_row(REG_COEF_OFFSET, 16'h8000),
            word_row(1'b1, 1'b1),
            word_row(1'b0, 1'b1),
            reg_row(REG_COEF_SQUARE, 16'h0000),
            reg_row(REG_COEF_LINEAR, 16'h0000),
            reg_row(REG_COEF_OFFSET, 16'h7FFF),
            // offset only gives 2047 m/s (Q8.8 raw); cutoff at top blanks it
            reg_row(REG_CUTOFF_MPS, 16'hFFFF),
            known_row(1'b0, 1'b1, 16'd0, 18'd0, 16'd0, 1'b0),
            reg_row(REG_CUTOFF_MPS, 16'd2046),
            known_row(1'b0, 1'b1, 16'd2047, 18'd7369, 16'd0, 1'b0),
            // equal to the cutoff is still blanked
            reg_row(REG_CUTOFF_MPS, 16'd2047),
            known_row(1'b1, 1'b1, 16'd0, 18'd0, 16'd1, 1'b0),
            // window lowered under the elapsed time: next word closes it
            reg_row(REG_WINDOW_MS, 16'd10),
            word_row(1'b1, 1'b1),
            word_row(1'b1, 1'b1),
            word_row(1'b1, 1'b1),
            reg_row(REG_WINDOW_MS, 16'd2),
            word_row(1'b0, 1'b0),
            // unmapped indexes must leave the calibration alone
            reg_row(3'd7, 16'hFFFF),
            reg_row(3'd5, 16'h0000),
            reg_row(3'd6, 16'h5A5A),
            word_row(1'b0, 1'b1),
            word_row(1'b1, 1'b1)
        };

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_REG)
                write_reg(script[i].idx, script[i].data);
            else
                push_word(script[i].word.pulse_edge, script[i].word.ms_tick,
                          script[i].known, script[i].report);
        end

        // Rate cap: 70 pulses in one tick exceeds the 24-bit rps limit;
        // a pure linear term of one makes the cap visible in m/s.
        write_reg(REG_WINDOW_MS, 16'd0);
        write_reg(REG_COEF_SQUARE, 16'h0000);
        write_reg(REG_COEF_LINEAR, 16'h0001);
        write_reg(REG_COEF_OFFSET, 16'h0000);
        write_reg(REG_CUTOFF_MPS, 16'h0000);
        repeat (70) push_word(1'b1, 1'b0, 1'b0, '0);
        push_word(1'b0, 1'b1, 1'b0, '0);

        // Random phases: new calibration, pulse and tick densities, and
        // idling style per phase; phases run on past the word count until
        // enough reports have been produced.
        rand_words  = 0;
        report_goal = reports_predicted + RAND_REPORTS;
        while (rand_words < RAND_WORDS || reports_predicted < report_goal) begin
            randomize_setup();
            tx_idle   = $urandom_range(3, 0) != 0;
            rx_eager  = $urandom_range(3, 0) == 0;
            pulse_pct = $urandom_range(100, 0);
            tick_pct  = $urandom_range(100, 5);
            span      = $urandom_range(120, 20);
            repeat (span) begin
                push_word($urandom_range(99, 0) < pulse_pct,
                          $urandom_range(99, 0) < tick_pct, 1'b0, '0);
                rand_words++;
            end
        end

        settle();
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
